// ===== rtl/core/pwic_pkg.sv =====
// shared widths, register indexes and stage word types for the pid block
package pwic_pkg;

    localparam int SAMPLE_W = 16;                 // measured and target
    localparam int ERR_W    = SAMPLE_W + 1;       // measured - target
    localparam int DIFF_W   = ERR_W + 1;          // err - previous err
    localparam int LIMIT_W  = 20;                 // integral clamp magnitude
    localparam int SUM_W    = LIMIT_W + 2;        // clamped integral, signed
    localparam int GAIN_W   = 24;                 // signed q7.16
    localparam int FRAC_W   = 16;
    localparam int PROD_P_W = GAIN_W + ERR_W;
    localparam int PROD_I_W = GAIN_W + SUM_W;
    localparam int PROD_D_W = GAIN_W + DIFF_W;
    localparam int ACC_W    = 48;
    localparam int DRIVE_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100000);

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd3;

    // word leaving the integrator stage
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
        logic                     at_limit;
    } integ_t;

    // word leaving the multiplier stage
    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
        logic                       at_limit;
    } prod_t;

endpackage

// ===== rtl/core/pwic_integrator.sv =====
// input register, error, clamped integral and derivative difference
module pwic_integrator
    import pwic_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] measured,
    input  logic signed [SAMPLE_W-1:0] target,
    input  logic        [LIMIT_W-1:0]  integral_limit,
    output logic                       out_valid,
    input  logic                       out_ready,
    output integ_t                     out_data
);

    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic signed [SAMPLE_W-1:0] meas_reg;
    logic signed [SAMPLE_W-1:0] targ_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    integ_t                     out_data_reg;
    integ_t                     out_data_next;
    logic signed [SUM_W-1:0]    error_sum_reg;
    logic signed [SUM_W-1:0]    error_sum_next;
    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [ERR_W-1:0]    prev_err_next;

    logic                       stage_ready;
    logic                       advance;
    logic signed [ERR_W-1:0]    err;
    logic signed [SUM_W-1:0]    raw_sum;
    logic signed [SUM_W-1:0]    lim_pos;
    logic signed [SUM_W-1:0]    lim_neg;
    logic signed [SUM_W-1:0]    clamped;

    assign stage_ready = !out_valid_reg || out_ready;
    assign in_ready    = !in_valid_reg || stage_ready;
    assign advance     = in_valid_reg && stage_ready;

    always_comb
    begin
        err     = ERR_W'(meas_reg) - ERR_W'(targ_reg);
        raw_sum = error_sum_reg + SUM_W'(err);
        lim_pos = SUM_W'($signed({1'b0, integral_limit}));
        lim_neg = -lim_pos;
        if (raw_sum > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (raw_sum < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = raw_sum;
        end

        out_data_next.err      = err;
        out_data_next.sum      = clamped;
        out_data_next.diff     = DIFF_W'(err) - DIFF_W'(prev_err_reg);
        out_data_next.at_limit = (clamped == lim_pos) || (clamped == lim_neg);

        in_valid_next  = in_ready ? in_valid : in_valid_reg;
        out_valid_next = stage_ready ? in_valid_reg : out_valid_reg;
        error_sum_next = advance ? clamped : error_sum_reg;
        prev_err_next  = advance ? err : prev_err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            error_sum_reg <= error_sum_next;
            prev_err_reg  <= prev_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            meas_reg <= measured;
            targ_reg <= target;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/pwic_mult.sv =====
// three gain products, registered
module pwic_mult
    import pwic_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  integ_t                   in_data,
    input  logic signed [GAIN_W-1:0] gain_p,
    input  logic signed [GAIN_W-1:0] gain_i,
    input  logic signed [GAIN_W-1:0] gain_d,
    output logic                     out_valid,
    input  logic                     out_ready,
    output prod_t                    out_data
);

    logic  out_valid_reg;
    logic  out_valid_next;
    prod_t out_data_reg;
    prod_t out_data_next;

    assign in_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_data_next.prod_p   = PROD_P_W'(gain_p) * PROD_P_W'(in_data.err);
        out_data_next.prod_i   = PROD_I_W'(gain_i) * PROD_I_W'(in_data.sum);
        out_data_next.prod_d   = PROD_D_W'(gain_d) * PROD_D_W'(in_data.diff);
        out_data_next.at_limit = in_data.at_limit;
        out_valid_next         = in_ready ? in_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/pwic_combine.sv =====
// product sum, q16 floor shift, 32-bit saturation and result register
module pwic_combine
    import pwic_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  prod_t                     in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      integral_saturated
);

    localparam logic signed [ACC_W-FRAC_W-1:0] DRIVE_MAX =
        (ACC_W-FRAC_W)'({1'b0, {(DRIVE_W-1){1'b1}}});
    localparam logic signed [ACC_W-FRAC_W-1:0] DRIVE_MIN =
        (ACC_W-FRAC_W)'($signed({1'b1, {(DRIVE_W-1){1'b0}}}));

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic signed [DRIVE_W-1:0]        drive_reg;
    logic signed [DRIVE_W-1:0]        drive_next;
    logic                             sat_reg;
    logic signed [ACC_W-1:0]          acc;
    logic signed [ACC_W-FRAC_W-1:0]   shifted;

    assign in_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        acc = ACC_W'(in_data.prod_p) + ACC_W'(in_data.prod_i) + ACC_W'(in_data.prod_d);
        // arithmetic shift floors toward minus infinity
        shifted = acc[ACC_W-1:FRAC_W];
        if (shifted > DRIVE_MAX)
        begin
            drive_next = DRIVE_MAX[DRIVE_W-1:0];
        end
        else if (shifted < DRIVE_MIN)
        begin
            drive_next = DRIVE_MIN[DRIVE_W-1:0];
        end
        else
        begin
            drive_next = shifted[DRIVE_W-1:0];
        end
        out_valid_next = in_ready ? in_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            drive_reg <= drive_next;
            sat_reg   <= in_data.at_limit;
        end
    end

    assign out_valid          = out_valid_reg;
    assign drive              = drive_reg;
    assign integral_saturated = sat_reg;

endmodule

// ===== rtl/core/pid_with_integral_clamp.sv =====
// positional pid controller with clamped integral, top level
//
// One word in, one word out. Each input word carries a measured sample and
// a setpoint; the error is measured minus target, it is added to the
// integral which is then clamped to plus or minus integral_limit, and the
// drive is (gain_p*err + gain_i*integral + gain_d*(err - last err)) >> 16,
// floored and saturated to signed 32 bits. tuser of the result flags the
// integral sitting at either limit (always set with a zero limit). The
// block is a four-register pipeline: input register, integrator register
// (where the running integral and last error are updated), product register
// holding the three multiplies, and the result register. While results
// are taken, a new word is taken every cycle; each stage holds its word
// while the stage after it is full, so while a result waits to be taken
// the input side keeps accepting until the three stages ahead of the
// result register are full. Gains and the limit are written through the
// cfg port (always ready); the user must write them only while no word
// is in flight, which the block does not enforce. Indexes are 0 gain_p,
// 1 gain_i, 2 gain_d, 3 integral_limit.
module pid_with_integral_clamp
    import pwic_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [GAIN_W-1:0]      cfg_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [2*SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] measured, [31:16] target
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [DRIVE_W-1:0]     m_axis_tdata,   // [31:0] drive
    output logic                   m_axis_tuser    // [0] integral_saturated
);

    // configuration registers
    logic signed [GAIN_W-1:0]  gain_p_reg;
    logic signed [GAIN_W-1:0]  gain_i_reg;
    logic signed [GAIN_W-1:0]  gain_d_reg;
    logic        [LIMIT_W-1:0] limit_reg;

    // stage links
    logic   integ_valid;
    logic   integ_ready;
    integ_t integ_data;
    logic   prod_valid;
    logic   prod_ready;
    prod_t  prod_data;
    logic signed [DRIVE_W-1:0] drive;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GAIN_P: gain_p_reg <= cfg_data;
                CFG_GAIN_I: gain_i_reg <= cfg_data;
                CFG_GAIN_D: gain_d_reg <= cfg_data;
                CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    // error, clamped integral, derivative difference
    pwic_integrator u_integrator (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .measured       (s_axis_tdata[SAMPLE_W-1:0]),
        .target         (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .integral_limit (limit_reg),
        .out_valid      (integ_valid),
        .out_ready      (integ_ready),
        .out_data       (integ_data)
    );

    // the three gain products in parallel
    pwic_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (integ_valid),
        .in_ready  (integ_ready),
        .in_data   (integ_data),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    // sum, shift, saturate into the result register
    pwic_combine u_combine (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (prod_valid),
        .in_ready           (prod_ready),
        .in_data            (prod_data),
        .out_valid          (m_axis_tvalid),
        .out_ready          (m_axis_tready),
        .drive              (drive),
        .integral_saturated (m_axis_tuser)
    );

    assign m_axis_tdata = drive;

    // an empty result register must never hold off the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with result register empty");

    // integrator word held while the multiplier stage is full
    assert property (@(posedge clk) disable iff (!rst_n)
        integ_valid && !integ_ready |=> integ_valid && $stable(integ_data))
        else $error("integrator word lost under stall");

    // product word held while the result register is full
    assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid && !prod_ready |=> prod_valid && $stable(prod_data))
        else $error("product word lost under stall");

endmodule
